@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the lane assigner.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ hw/rtl/ifla_pkg.sv @@
// Types and constants of the interval first-fit lane assigner.
// No dependencies; used by ifla_ctrl and the top level.
`default_nettype none
package ifla_pkg;

    localparam int FIELD_TIME_W = 24;
    localparam int CHAN_W       = 10;
    localparam int LANE_OUT_W   = 4;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ifla_state_t;

    typedef struct packed {
        logic [FIELD_TIME_W-1:0] note_start;
        logic [FIELD_TIME_W-1:0] note_length;
        logic [CHAN_W-1:0]       channel_id;
        logic                    new_group;
    } ifla_note_t;

    typedef struct packed {
        logic [CHAN_W-1:0]      channel_out;
        logic [LANE_OUT_W-1:0]  lane_index;
        logic                   overflow;
        logic [COUNT_OUT_W-1:0] lane_count;
    } ifla_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ifla_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ifla_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ifla_ctrl.sv @@
// Lane scan controller: holds the lane memory, scans it one lane per cycle
// and commits the placement. Depends on ifla_pkg and ifla_ram.
`default_nettype none
module ifla_ctrl #(
    parameter int LANES     = 16,
    parameter int TIME_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ifla_pkg::ifla_note_t  in_note,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ifla_pkg::ifla_result_t res
);
    import ifla_pkg::*;

    localparam int TW  = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
    localparam int LIW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW  = $clog2(LANES + 1);
    localparam int MW  = 2 * TW + 1;

    ifla_state_t state_reg, state_next;

    logic [TW-1:0]     start_reg, start_next;
    logic [TW:0]       end_reg, end_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [CW-1:0]     open_reg, open_next;
    logic [LIW-1:0]    idx_reg, idx_next;
    logic              found_reg, found_next;

    logic              rd_en;
    logic [LIW-1:0]    rd_addr;
    logic [MW-1:0]     rd_data;
    logic              wr_en;
    logic [LIW-1:0]    wr_addr;

    logic [TW-1:0]     in_start;
    logic [TW-1:0]     in_len;
    logic [TW:0]       in_end;
    logic [CW-1:0]     accept_open;
    logic [TW-1:0]     lane_start;
    logic [TW:0]       lane_end;
    logic              overlap;
    logic              last_lane;
    logic              can_open;
    logic [CW-1:0]     open_after;
    logic [CW-1:0]     count;
    logic [LIW-1:0]    lane_sel;
    logic [LIW+LANE_OUT_W-1:0] lane_wide;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    // Input side: time fields cut to the configured width; a zero length is one tick.
    assign in_start    = in_note.note_start[TW-1:0];
    assign in_len      = in_note.note_length[TW-1:0];
    assign in_end      = {1'b0, in_start} + ((in_len == '0) ? (TW+1)'(1) : {1'b0, in_len});
    assign accept_open = in_note.new_group ? '0 : open_reg;

    // Each memory word keeps the lane's last note as {end, start}.
    assign lane_start = rd_data[TW-1:0];
    assign lane_end   = rd_data[MW-1:TW];
    assign overlap    = ({1'b0, lane_start} < end_reg) && ({1'b0, start_reg} < lane_end);
    assign last_lane  = (CW'(CW'(idx_reg) + CW'(1)) == open_reg);

    assign can_open   = (open_reg < CW'(LANES));
    assign open_after = (!found_reg && can_open) ? CW'(open_reg + CW'(1)) : open_reg;
    assign count      = (open_after == '0) ? CW'(1) : open_after;
    assign lane_sel   = found_reg ? idx_reg : (can_open ? open_reg[LIW-1:0] : '0);
    assign lane_wide  = {{LANE_OUT_W{1'b0}}, lane_sel};
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count};

    ifla_ram #(
        .WIDTH (MW),
        .DEPTH (LANES)
    ) u_lane_mem (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({end_reg, start_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (accept_open == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!overlap || last_lane) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshakes and memory ports.
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = lane_sel;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            ST_SCAN: begin
                rd_en   = overlap && !last_lane;
                rd_addr = idx_reg + LIW'(1);
            end
            ST_FINISH: begin
                res_valid = 1'b1;
                wr_en     = res_ready && (found_reg || can_open);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        chan_next  = chan_reg;
        open_next  = open_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    start_next = in_start;
                    end_next   = in_end;
                    chan_next  = in_note.channel_id;
                    open_next  = accept_open;
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (!overlap) begin
                    found_next = 1'b1;
                end else if (!last_lane) begin
                    idx_next = idx_reg + LIW'(1);
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    open_next = open_after;
                end
            end
            default: begin
                found_next = found_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            open_reg  <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        chan_reg  <= chan_next;
    end

    assign res.channel_out = chan_reg;
    assign res.lane_index  = lane_wide[LANE_OUT_W-1:0];
    assign res.overflow    = !found_reg && !can_open;
    assign res.lane_count  = count_wide[COUNT_OUT_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/interval_first_fit_lane_assign.sv @@
// Top level of the interval first-fit lane assigner: stream ports and output register.
// Depends on ifla_pkg, ifla_ctrl (with ifla_ram) and assert_macros.svh.
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+--------------------------------------
//  s_      | in        | s_tvalid/s_tready  | one note: start, length, channel, new group
//  m_      | out       | m_tvalid/m_tready  | one placement: channel, lane, count, overflow
//
// An item is accepted in the idle state; if any lane is open, the scan state then reads
// the open lanes in order until a fit is found (at most LANES of them), and the finish
// state commits it. The scan is paced by the lane memory, which has one read port
// and is scanned one lane per cycle. Reset clears the controller and the open-lane count;
// the lane memory is not cleared, since a lane is always written when it is opened.
// A stalled result waits in the output register; the controller holds its commit
// until that register is free, and takes no new item meanwhile.
`default_nettype none
`include "assert_macros.svh"
module interval_first_fit_lane_assign #(
    parameter int LANES     = 16,
    parameter int TIME_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // note_start[23:0], note_length[47:24], channel_id[57:48]
    input  logic        s_tuser,   // new_group
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // channel_out[9:0], lane_index[13:10], lane_count[18:14]
    output logic        m_tuser    // overflow
);
    import ifla_pkg::*;

    ifla_note_t   note;
    ifla_result_t res;
    logic         res_valid;
    logic         res_ready;

    logic         m_tvalid_reg, m_tvalid_next;
    ifla_result_t out_reg, out_next;

    // Unpack the input item; the channel sits right above the two time fields.
    assign note.note_start  = s_tdata[FIELD_TIME_W-1:0];
    assign note.note_length = s_tdata[2*FIELD_TIME_W-1:FIELD_TIME_W];
    assign note.channel_id  = s_tdata[2*FIELD_TIME_W+CHAN_W-1:2*FIELD_TIME_W];
    assign note.new_group   = s_tuser;

    ifla_ctrl #(
        .LANES     (LANES),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_note   (note),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register can take a new result when empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.lane_count, out_reg.lane_index, out_reg.channel_out};
    assign m_tuser  = out_reg.overflow;

    // An overflowed note is always reported on lane zero.
    `ASSERT_CLK(a_ovf_lane_zero, aclk, aresetn,
        (m_tvalid && m_tuser) |-> (m_tdata[13:10] == 4'd0))
    // A placed note lies on a lane below the open-lane count.
    `ASSERT_CLK(a_lane_below_count, aclk, aresetn,
        (m_tvalid && !m_tuser && (LANES <= 16)) |-> (m_tdata[13:10] < m_tdata[18:14]))
    // The controller never takes a note while it still offers a result.
    `ASSERT_NEVER(a_accept_while_commit, aclk, aresetn, s_tready && res_valid)

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for interval_first_fit_lane_assign: a first-fit lane predictor
// in a small scoreboard class, with stream drivers that stall and idle at random.
// Depends on ifla_pkg and the RTL of the lane assigner; reads no files.
`default_nettype none
module tb;
    import ifla_pkg::*;

    localparam int          NUM_LANES    = 16;
    localparam int          RANDOM_NOTES = 1030;
    // The last notes of the random part run with no idling on either side.
    localparam int          QUIET_NOTES  = 150;
    // A run has near 1050 items; the limit lies above the slowest correct run.
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [23:0] TIME_MAX     = 24'hFFFFFF;

    // Greedy first-fit placement of notes into lanes, and the queue of placements
    // that the block still owes.
    class lane_scoreboard;
        logic [FIELD_TIME_W-1:0] last_start[NUM_LANES];
        logic [FIELD_TIME_W-1:0] last_length[NUM_LANES];
        int unsigned             open_lanes = 0;
        ifla_result_t            placements[$];
        int unsigned             errors = 0;

        // A length of zero still covers one tick. Ends are one bit wider than the
        // time fields, so a note near the top of the range does not wrap.
        function bit intervals_overlap(logic [23:0] a_start, logic [23:0] a_len,
                                       logic [23:0] b_start, logic [23:0] b_len);
            logic [24:0] a_end;
            logic [24:0] b_end;
            a_end = {1'b0, a_start} + ((a_len == 0) ? 25'd1 : {1'b0, a_len});
            b_end = {1'b0, b_start} + ((b_len == 0) ? 25'd1 : {1'b0, b_len});
            return ({1'b0, a_start} < b_end) && ({1'b0, b_start} < a_end);
        endfunction

        // Places one accepted note and queues the placement the block must report.
        function void note_accepted(ifla_note_t n);
            ifla_result_t r;
            int unsigned  lane;
            int unsigned  chosen;
            bit           placed;
            placed = 0;
            chosen = 0;
            r.channel_out = n.channel_id;
            r.overflow    = 1'b0;
            if (n.new_group)
                open_lanes = 0;
            for (lane = 0; lane < open_lanes; lane++) begin
                if (!intervals_overlap(last_start[lane], last_length[lane],
                                       n.note_start, n.note_length)) begin
                    chosen = lane;
                    placed = 1;
                    break;
                end
            end
            if (!placed) begin
                if (open_lanes < NUM_LANES) begin
                    chosen = open_lanes;
                    open_lanes++;
                    placed = 1;
                end else begin
                    // Every lane is open and in conflict: report lane 0, keep all state.
                    r.overflow = 1'b1;
                end
            end
            if (placed) begin
                last_start[chosen]  = n.note_start;
                last_length[chosen] = n.note_length;
            end
            r.lane_index = chosen[LANE_OUT_W-1:0];
            r.lane_count = (open_lanes == 0) ? 5'd1 : open_lanes[COUNT_OUT_W-1:0];
            placements.push_back(r);
        endfunction

        function void check_result(ifla_result_t got);
            ifla_result_t want;
            if (placements.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: chan %0d lane %0d ovf %0d count %0d",
                             got.channel_out, got.lane_index, got.overflow, got.lane_count);
                return;
            end
            want = placements.pop_front();
            if (got.channel_out !== want.channel_out || got.lane_index !== want.lane_index ||
                got.overflow !== want.overflow || got.lane_count !== want.lane_count) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected chan %0d lane %0d ovf %0d count %0d,",
                              " got chan %0d lane %0d ovf %0d count %0d"},
                             want.channel_out, want.lane_index, want.overflow,
                             want.lane_count, got.channel_out, got.lane_index,
                             got.overflow, got.lane_count);
            end
        endfunction

        function int unsigned pending();
            return placements.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // note_start[23:0], note_length[47:24], channel_id[57:48]
    logic        s_tuser  = 1'b0; // new_group
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // channel_out[9:0], lane_index[13:10], lane_count[18:14]
    logic        m_tuser;         // overflow

    lane_scoreboard placement_board = new();

    int unsigned cycle_count     = 0;
    int unsigned random_sent     = 0;
    bit          quiet           = 0;
    bit          sender_idles    = 0;
    bit          receiver_stalls = 1;

    always #1 aclk = ~aclk;

    interval_first_fit_lane_assign #(
        .LANES(NUM_LANES),
        .TIME_BITS(FIELD_TIME_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // A hung block ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** interval_first_fit_lane_assign: FAILED **");
            $finish;
        end
    end

    // Offers one note and returns at the edge where it is accepted. An optional idle
    // burst comes first; otherwise tvalid simply stays high from the previous item,
    // so it is never lowered and raised within one time step.
    task automatic send_note(input ifla_note_t n);
        int unsigned gap;
        if (sender_idles && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        // The six bits above the channel are padding and stay zero.
        s_tdata  <= {6'b0, n.channel_id, n.note_length, n.note_start};
        s_tuser  <= n.new_group;
        do @(posedge aclk); while (!s_tready);
        placement_board.note_accepted(n);
    endtask

    task automatic send_fields(input logic [23:0] start, input logic [23:0] length,
                               input logic [9:0] chan, input logic fresh);
        ifla_note_t n;
        n.note_start  = start;
        n.note_length = length;
        n.channel_id  = chan;
        n.new_group   = fresh;
        send_note(n);
    endtask

    // Holds the input side off until every placement owed has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (placement_board.pending() != 0) @(posedge aclk);
    endtask

    // One group of notes in start order, with the group's density picked at random,
    // or a burst of unordered noise with stray new-group flags.
    task automatic send_group();
        ifla_note_t  n;
        int unsigned kind;
        int unsigned count;
        int unsigned step_max;
        int unsigned len_lo;
        int unsigned len_hi;
        int unsigned i;
        logic [23:0] t;
        kind         = $urandom_range(0, 9);
        count        = $urandom_range(4, 40);
        sender_idles = $urandom_range(0, 1);
        step_max     = $urandom_range(1, 40);
        len_lo       = 0;
        len_hi       = $urandom_range(1, 200);
        if (kind == 5 || kind == 6) begin
            // Long notes close together pile up and can take every lane.
            step_max = $urandom_range(0, 3);
            len_lo   = 100;
            len_hi   = 3000;
        end else if (kind == 7) begin
            // Zero and one tick notes, where the one-tick rule decides the overlap.
            step_max = $urandom_range(0, 1);
            len_hi   = 1;
        end
        // Some groups start near the top of the time range, where ends pass 2^24.
        if ($urandom_range(0, 3) == 0)
            t = TIME_MAX - 24'($urandom_range(0, 2000));
        else
            t = 24'($urandom);
        for (i = 0; i < count && random_sent < RANDOM_NOTES; i++) begin
            quiet = (random_sent >= RANDOM_NOTES - QUIET_NOTES);
            n.channel_id = 10'($urandom);
            if (kind >= 8) begin
                n.note_start  = 24'($urandom);
                n.note_length = $urandom_range(0, 1) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 50));
                n.new_group   = ($urandom_range(0, 3) == 0);
            end else begin
                n.note_start  = t;
                n.note_length = 24'($urandom_range(len_lo, len_hi));
                n.new_group   = (i == 0);
                t = t + 24'($urandom_range(0, step_max));
            end
            send_note(n);
            random_sent++;
        end
    endtask

    // Result side: checks every accepted item and stalls in random bursts. Stall
    // bursts come and go in stretches and stop in the quiet part at the end.
    initial begin
        int unsigned  hold;
        ifla_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.channel_out = m_tdata[9:0];
                got.lane_index  = m_tdata[13:10];
                got.lane_count  = m_tdata[18:14];
                got.overflow    = m_tuser;
                placement_board.check_result(got);
            end
            if ($urandom_range(0, 99) == 0)
                receiver_stalls = ~receiver_stalls;
            if (aresetn && receiver_stalls && !quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    initial begin
        int unsigned i;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first note after reset finds no lane open and opens lane 0 without a
        // new-group flag. It spans the whole time range, so the next fifteen overlap
        // it and each other and open lanes 1 to 15.
        send_fields(24'd0, TIME_MAX, 10'd1023, 1'b0);
        for (i = 1; i < NUM_LANES; i++)
            send_fields(24'(i), 24'd1000, 10'(i), 1'b0);
        // All sixteen lanes conflict: overflow, and the state must stay as it was.
        send_fields(24'd20, 24'd0, 10'd512, 1'b0);
        // Starts where lane 0's note ends and fits there; its own end lies past 2^24.
        send_fields(TIME_MAX, TIME_MAX, 10'd1, 1'b0);
        // A zero length note on that same tick overlaps lane 0 but fits lane 1.
        send_fields(TIME_MAX, 24'd0, 10'd2, 1'b0);
        // A new group closes every lane; then zero lengths count as one tick each.
        send_fields(24'd5, 24'd0, 10'd3, 1'b1);
        send_fields(24'd5, 24'd0, 10'd4, 1'b0);
        send_fields(24'd6, 24'd0, 10'd5, 1'b0);
        // Notes out of order are placed by the same rule.
        send_fields(24'd2, 24'd1, 10'd6, 1'b0);
        send_fields(24'd0, 24'd2, 10'd7, 1'b0);

        // The input side waits here until the block has answered everything.
        drain_results();

        while (random_sent < RANDOM_NOTES)
            send_group();

        drain_results();
        repeat (2 * NUM_LANES + 8) @(posedge aclk);
        if (placement_board.errors == 0 && placement_board.pending() == 0)
            $display("** interval_first_fit_lane_assign: PASSED **");
        else
            $display("** interval_first_fit_lane_assign: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ifla_pkg.sv
hw/rtl/ifla_ram.sv
hw/rtl/ifla_ctrl.sv
hw/rtl/interval_first_fit_lane_assign.sv
sim/tb.sv
